@@ design/sha1_stream_hash_core_assert.svh @@
// Assertion macros for the SHA-1 stream hash core
`ifndef SHA1_STREAM_HASH_CORE_ASSERT_SVH
`define SHA1_STREAM_HASH_CORE_ASSERT_SVH
// condition checked on every rising clock edge outside reset
`define SHA_ASSERT_IMP(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// next-cycle implication
`define SHA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`endif

@@ design/sha1s_pkg.sv @@
// Package with SHA-1 constants, types and round helpers
package sha1s_pkg;
    localparam int unsigned HashWords = 5;
    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds = 80;
    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [7:0] PadByte = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       start;
    } rnd_ctl_t;

    function automatic logic [31:0] round_k(input logic [6:0] r);
        logic [31:0] k;
        begin
            if (r < 7'd20)      k = 32'h5A827999;
            else if (r < 7'd40) k = 32'h6ED9EBA1;
            else if (r < 7'd60) k = 32'h8F1BBCDC;
            else                k = 32'hCA62C1D6;
            return k;
        end
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        begin
            if (r < 7'd20)      f = (b & c) | (~b & d);
            else if (r < 7'd40) f = b ^ c ^ d;
            else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
            else                f = b ^ c ^ d;
            return f;
        end
    endfunction

    function automatic logic [31:0] init_word(input logic [2:0] i);
        logic [31:0] h;
        begin
            unique case (i)
                3'd0:    h = H0;
                3'd1:    h = H1;
                3'd2:    h = H2;
                3'd3:    h = H3;
                default: h = H4;
            endcase
            return h;
        end
    endfunction
endpackage

@@ design/sha1_stream_hash_core.sv @@
// Top level of the SHA-1 stream hash core
// Usage:
//   Input channel (in_valid/in_ready) takes one word per handshake: data_byte,
//   has_byte and last. Output channel (out_valid/out_ready) gives the digest as
//   five words, word_index 0 to 4, last_word set on the fifth.
//   A word without a byte or last, or with a byte that does not fill the block,
//   leaves in_ready high. The byte that fills a block starts a compression: the
//   block is read out of the buffer, the round unit runs the 80 rounds, the
//   result is added into the chaining value and the core settles; in_ready stays
//   low through the whole compression.
//   A word with last pads the block one byte per cycle up to the block end, then
//   compresses; when the marker lands at byte 56 or later a further block of
//   padding and a second compression follow. Then five digest words
//   are presented, one per cycle while out_ready is high. A stall on the output
//   holds the current word; no input is taken until the fifth digest word leaves.
//   The block buffer is a 64-entry byte memory written at most one byte a cycle and read
//   two bytes a cycle into the block register when a compression starts.
//   Reset loads the initial chaining value, clears the bit count and idles both
//   channels; no clearing pass is needed.
`include "sha1_stream_hash_core_assert.svh"
module sha1_stream_hash_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    sha1s_pkg::state_t state_reg, state_next;
    logic [63:0] cnt_reg, cnt_next;
    logic [5:0]  pos_reg, pos_next;
    logic        fin_reg, fin_next;
    logic        lenblk_reg, lenblk_next;
    logic        fill_reg, fill_next;
    logic        lendone_reg, lendone_next;
    logic [5:0]  ld_reg, ld_next;
    logic [2:0]  idx_reg, idx_next;
    logic [31:0] chain_reg [5];
    logic [7:0]  buf_mem [64];
    logic [511:0] blk_reg;
    logic [31:0] blk_word [16];
    logic [31:0] work [5];
    logic        wr_en;
    logic [5:0]  wr_addr;
    logic [7:0]  wr_data;
    logic        rd_en;
    logic [5:0]  rd_addr;
    logic        chain_add, chain_init;
    logic        rdone;
    sha1s_pkg::rnd_ctl_t rctl;
    logic        accept;

    assign accept  = in_valid && in_ready;
    assign rd_addr = {ld_reg[4:0], 1'b0};

    always_ff @(posedge clk)
    begin
        if (wr_en)
            buf_mem[wr_addr] <= wr_data;
        if (rd_en)
            blk_reg <= {blk_reg[495:0], buf_mem[rd_addr], buf_mem[rd_addr + 6'd1]};
    end

    always_comb
    begin
        for (int i = 0; i < 16; i++)
            blk_word[i] = blk_reg[511 - 32*i -: 32];
    end

    sha1s_rounds u_rounds (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (rctl),
        .blk_word (blk_word),
        .chain_in (chain_reg),
        .work_out (work),
        .done     (rdone)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sha1s_pkg::ST_IDLE;
            cnt_reg     <= '0;
            pos_reg     <= '0;
            fin_reg     <= 1'b0;
            lenblk_reg  <= 1'b0;
            fill_reg    <= 1'b0;
            lendone_reg <= 1'b0;
            ld_reg      <= '0;
            idx_reg     <= '0;
            for (int i = 0; i < 5; i++)
                chain_reg[i] <= sha1s_pkg::init_word(3'(i));
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pos_reg     <= pos_next;
            fin_reg     <= fin_next;
            lenblk_reg  <= lenblk_next;
            fill_reg    <= fill_next;
            lendone_reg <= lendone_next;
            ld_reg      <= ld_next;
            idx_reg     <= idx_next;
            for (int i = 0; i < 5; i++)
            begin
                if (chain_init)
                    chain_reg[i] <= sha1s_pkg::init_word(3'(i));
                else if (chain_add)
                    chain_reg[i] <= chain_reg[i] + work[i];
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        fin_next     = fin_reg;
        lenblk_next  = lenblk_reg;
        fill_next    = fill_reg;
        lendone_next = lendone_reg;
        ld_next      = ld_reg;
        idx_next     = idx_reg;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = data_byte;
        rd_en        = 1'b0;
        chain_add    = 1'b0;
        chain_init   = 1'b0;
        rctl         = '0;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        unique case (state_reg)
            sha1s_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    fin_next     = last;
                    lenblk_next  = 1'b0;
                    fill_next    = 1'b0;
                    lendone_next = 1'b0;
                    if (has_byte)
                    begin
                        wr_en    = 1'b1;
                        cnt_next = cnt_reg + 64'd8;
                        pos_next = pos_reg + 6'd1;
                        if (pos_reg == 6'd63)
                            state_next = sha1s_pkg::ST_LOAD;
                        else if (last)
                            state_next = sha1s_pkg::ST_PAD;
                    end
                    else if (last)
                        state_next = sha1s_pkg::ST_PAD;
                end
            end
            sha1s_pkg::ST_PAD:
            begin
                // write marker, zeros, then length bytes
                wr_en = 1'b1;
                if (!lenblk_reg)
                begin
                    wr_data     = sha1s_pkg::PadByte;
                    lenblk_next = 1'b1;
                    fill_next   = (pos_reg >= 6'd56) && (pos_reg != 6'd63);
                    pos_next    = pos_reg + 6'd1;
                    if (pos_reg == 6'd63)
                        state_next = sha1s_pkg::ST_LOAD;
                end
                else if (fill_reg)
                begin
                    wr_data  = 8'h00;
                    pos_next = pos_reg + 6'd1;
                    if (pos_reg == 6'd63)
                    begin
                        fill_next  = 1'b0;
                        state_next = sha1s_pkg::ST_LOAD;
                    end
                end
                else if (pos_reg < 6'd56)
                begin
                    wr_data  = 8'h00;
                    pos_next = pos_reg + 6'd1;
                end
                else
                begin
                    wr_data  = 8'(cnt_reg >> (7'd8 * 7'(6'd63 - pos_reg)));
                    pos_next = pos_reg + 6'd1;
                    if (pos_reg == 6'd63)
                    begin
                        lendone_next = 1'b1;
                        state_next   = sha1s_pkg::ST_LOAD;
                    end
                end
            end
            sha1s_pkg::ST_LOAD:
            begin
                // read two bytes a cycle into the block register
                rd_en   = !ld_reg[5];
                ld_next = ld_reg + 6'd1;
                if (ld_reg[5])
                begin
                    ld_next    = '0;
                    rctl.start = 1'b1;
                    state_next = sha1s_pkg::ST_ROUND;
                end
            end
            sha1s_pkg::ST_ROUND:
            begin
                if (rdone)
                begin
                    chain_add = 1'b1;
                    state_next = sha1s_pkg::ST_ADD;
                end
            end
            sha1s_pkg::ST_ADD:
            begin
                // block done: continue padding, emit, or take more bytes
                if (fin_reg)
                begin
                    if (lendone_reg)
                    begin
                        idx_next   = 3'd0;
                        state_next = sha1s_pkg::ST_EMIT;
                    end
                    else
                        state_next = sha1s_pkg::ST_PAD;
                end
                else
                    state_next = sha1s_pkg::ST_IDLE;
            end
            sha1s_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'(sha1s_pkg::HashWords - 1))
                    begin
                        idx_next   = 3'd0;
                        chain_init = 1'b1;
                        cnt_next   = '0;
                        pos_next   = '0;
                        fin_next   = 1'b0;
                        state_next = sha1s_pkg::ST_IDLE;
                    end
                end
            end
            default:
                state_next = sha1s_pkg::ST_IDLE;
        endcase
    end

    assign digest_word = chain_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 3'(sha1s_pkg::HashWords - 1));

    `SHA_ASSERT_IMP(a_out_idx, clk, rst_n, !out_valid || idx_reg < 3'd5,
        "digest index out of range")
    `SHA_ASSERT_IMP(a_excl, clk, rst_n, !(in_ready && out_valid),
        "input and output open together")
    `SHA_ASSERT_NEXT(a_emit_done, clk, rst_n, out_valid && out_ready && last_word,
        cnt_reg == 64'd0, "bit count not cleared after digest")
endmodule

@@ design/sha1s_rounds.sv @@
// SHA-1 compression rounds over a schedule window memory
`include "sha1_stream_hash_core_assert.svh"
module sha1s_rounds (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sha1s_pkg::rnd_ctl_t  ctl,
    input  logic [31:0]          blk_word [16],
    input  logic [31:0]          chain_in [5],
    output logic [31:0]          work_out [5],
    output logic                 done
);
    logic [6:0]  round_reg;
    logic        run_reg;
    logic [31:0] win_reg [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] w;
    logic [31:0] w_new;
    logic [3:0]  slot;
    logic [31:0] tmp;

    assign slot  = round_reg[3:0];
    assign w_new = {win_reg[slot + 4'd13] ^ win_reg[slot + 4'd8] ^ win_reg[slot + 4'd2]
                    ^ win_reg[slot]} << 1
                 | {win_reg[slot + 4'd13] ^ win_reg[slot + 4'd8] ^ win_reg[slot + 4'd2]
                    ^ win_reg[slot]} >> 31;
    assign w     = (round_reg < 7'd16) ? win_reg[slot] : w_new;
    assign tmp   = {a_reg[26:0], a_reg[31:27]} + sha1s_pkg::round_f(round_reg, b_reg, c_reg,
                   d_reg) + e_reg + sha1s_pkg::round_k(round_reg) + w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            round_reg <= '0;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (ctl.start)
            begin
                run_reg   <= 1'b1;
                round_reg <= '0;
            end
            else if (run_reg)
            begin
                if (round_reg == 7'(sha1s_pkg::Rounds - 1))
                begin
                    run_reg <= 1'b0;
                    done    <= 1'b1;
                end
                round_reg <= round_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            win_reg <= blk_word;
            a_reg <= chain_in[0];
            b_reg <= chain_in[1];
            c_reg <= chain_in[2];
            d_reg <= chain_in[3];
            e_reg <= chain_in[4];
        end
        else if (run_reg)
        begin
            win_reg[slot] <= w;
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            b_reg <= a_reg;
            a_reg <= tmp;
        end
    end

    assign work_out[0] = a_reg;
    assign work_out[1] = b_reg;
    assign work_out[2] = c_reg;
    assign work_out[3] = d_reg;
    assign work_out[4] = e_reg;

    `SHA_ASSERT_IMP(a_round_range, clk, rst_n, !run_reg || round_reg < 7'd80,
        "round counter out of range")
    `SHA_ASSERT_NEXT(a_done_ends, clk, rst_n, done, !run_reg, "rounds still running after done")
    `SHA_ASSERT_IMP(a_no_restart, clk, rst_n, !(ctl.start && run_reg),
        "start while rounds busy")
endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the SHA-1 stream hash core: directed table, padding boundary lengths, then random messages
module testbench;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        has_byte = 1'b0;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        fin;
    } digest_out_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        valid_byte;
        logic        fin;
        logic        typed;
        logic [31:0] word0;
    } stim_row_t;

    sha1_stream_hash_core u_top (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    logic [31:0] hash_st [5];
    logic [7:0]  blk [64];
    logic [63:0] nbits;
    digest_out_t digest_q [$];
    logic [31:0] typed_q [$];
    int          fails = 0;
    int          stall_cycles = 0;
    int          sent = 0;
    bit          quiet = 1'b0;

    function automatic logic [31:0] rol(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    task automatic sha_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        int r;
        for (r = 0; r < 16; r++)
            w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
        a = hash_st[0]; b = hash_st[1]; c = hash_st[2]; d = hash_st[3]; e = hash_st[4];
        for (r = 0; r < 80; r++)
        begin
            if (r >= 16)
                w[r%16] = rol(w[(r+13)%16] ^ w[(r+8)%16] ^ w[(r+2)%16] ^ w[r%16], 1);
            if (r < 20)      begin f = (b & c) | (~b & d);          k = 32'h5A827999; end
            else if (r < 40) begin f = b ^ c ^ d;                   k = 32'h6ED9EBA1; end
            else if (r < 60) begin f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC; end
            else             begin f = b ^ c ^ d;                   k = 32'hCA62C1D6; end
            t = rol(a, 5) + f + e + k + w[r%16];
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d; hash_st[4] += e;
    endtask

    task automatic restart_digest();
        hash_st[0] = sha1s_pkg::H0;
        hash_st[1] = sha1s_pkg::H1;
        hash_st[2] = sha1s_pkg::H2;
        hash_st[3] = sha1s_pkg::H3;
        hash_st[4] = sha1s_pkg::H4;
        nbits = '0;
    endtask

    task automatic predict_digest(input logic [7:0] db, input logic hb, input logic ls);
        int p, i;
        p = nbits[8:3];
        if (hb)
        begin
            blk[p] = db;
            nbits += 64'd8;
            p = (p + 1) % 64;
            if (p == 0)
                sha_compress();
        end
        if (ls)
        begin
            blk[p] = sha1s_pkg::PadByte;
            p = p + 1;
            if (p > 56)
            begin
                while (p < 64)
                begin
                    blk[p] = 8'h00;
                    p = p + 1;
                end
                sha_compress();
                p = 0;
            end
            while (p < 56)
            begin
                blk[p] = 8'h00;
                p = p + 1;
            end
            for (i = 0; i < 8; i++)
                blk[56+i] = nbits[63-8*i -: 8];
            sha_compress();
            for (i = 0; i < 5; i++)
                digest_q.push_back('{hash_st[i], 3'(i), i == 4});
            restart_digest();
        end
    endtask

    task automatic send_word(input logic [7:0] db, input logic hb, input logic ls);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 18);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= db;
        has_byte <= hb;
        last <= ls;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_digest(db, hb, ls);
        sent++;
    endtask

    task automatic send_message(input int len, input bit tail_empty);
        int i;
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_word(8'($urandom), 1'b0, 1'b0);
            send_word(8'($urandom), 1'b1, !tail_empty && i == len - 1);
        end
        if (tail_empty || len == 0)
            send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    // output side: random stalls, compare against oldest expectation
    initial
    begin
        int gap;
        digest_out_t exp_w;
        logic [31:0] typed_w;
        @(posedge rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                gap = $urandom_range(1, 18);
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            if (out_valid)
            begin
                if (digest_q.size() == 0)
                begin
                    $error("unexpected digest word %h", digest_word);
                    fails++;
                end
                else
                begin
                    exp_w = digest_q.pop_front();
                    if (exp_w.index == 3'd0 && typed_q.size() != 0)
                    begin
                        typed_w = typed_q.pop_front();
                        if (typed_w !== digest_word)
                        begin
                            $error("digest_word expected %h actual %h", typed_w, digest_word);
                            fails++;
                        end
                    end
                    if (digest_word !== exp_w.word)
                    begin
                        $error("digest_word expected %h actual %h", exp_w.word, digest_word);
                        fails++;
                    end
                    if (word_index !== exp_w.index)
                    begin
                        $error("word_index expected %0d actual %0d", exp_w.index, word_index);
                        fails++;
                    end
                    if (last_word !== exp_w.fin)
                    begin
                        $error("last_word expected %0d actual %0d", exp_w.fin, last_word);
                        fails++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 20000)
        begin
            $display("sha1_stream_hash_core verification failed");
            $finish;
        end
    end

    stim_row_t dir_rows [] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, 32'hDA39A3EE},
        '{8'h61, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h63, 1'b1, 1'b1, 1'b1, 32'hA9993E36},
        '{8'hFF, 1'b1, 1'b1, 1'b0, 32'h0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'hFF, 1'b0, 1'b1, 1'b0, 32'h0}
    };

    initial
    begin
        int i;
        restart_digest();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].typed)
                typed_q.push_back(dir_rows[i].word0);
            send_word(dir_rows[i].data, dir_rows[i].valid_byte, dir_rows[i].fin);
        end
        // padding boundary lengths
        send_message(55, 1'b0);
        send_message(56, 1'b0);
        send_message(63, 1'b1);
        send_message(64, 1'b0);
        in_valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        while (sent < 430)
        begin
            i = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 12);
            send_message(i, $urandom_range(0, 3) == 0);
            if (sent > 380)
                quiet = 1'b1;
        end
        in_valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (fails == 0)
            $display("sha1_stream_hash_core verification clean");
        else
            $display("sha1_stream_hash_core verification failed");
        $finish;
    end
endmodule
